// ----- hdl/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, codes and the YCbCr matrix coefficient table for the
// pixel to RGBA converter.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int BYTE_W     = 8;
  localparam int COEF_W     = 10;  // unsigned coefficient magnitude, max 584
  localparam int OPND_W     = 10;  // signed luma / chroma operand after offset
  localparam int SUM_W      = 21;  // signed matrix sum before rounding
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;   // widest register (source_format)

  typedef enum logic [1:0] {
    MTX_BT601  = 2'd0,
    MTX_BT709  = 2'd1,
    MTX_BT2020 = 2'd2
  } matrix_t;

  typedef enum logic [2:0] {
    FMT_YCBCR  = 3'd0,
    FMT_RGB24  = 3'd1,
    FMT_BGR24  = 3'd2,
    FMT_BGRA32 = 3'd3,
    FMT_GRAY8  = 3'd4
  } format_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_SELECT = 2'd0,
    REG_FULL_RANGE    = 2'd1,
    REG_SOURCE_FORMAT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [1:0] matrix_select;
    logic       full_range;
    logic [2:0] source_format;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
    logic [BYTE_W-1:0] fourth;
  } pixel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
  } rgba_t;

  // luma, R from Cr, G from Cb, G from Cr, B from Cb (G terms subtracted)
  typedef struct packed {
    logic [COEF_W-1:0] luma;
    logic [COEF_W-1:0] r_cr;
    logic [COEF_W-1:0] g_cb;
    logic [COEF_W-1:0] g_cr;
    logic [COEF_W-1:0] b_cb;
  } coef_t;

  function automatic coef_t coef_lookup(input logic [1:0] mtx, input logic full);
    coef_t k;
    if (full) begin
      case (mtx)
        MTX_BT709:  k = '{10'd256, 10'd403, 10'd48, 10'd120, 10'd475};
        MTX_BT2020: k = '{10'd256, 10'd360, 10'd41, 10'd107, 10'd512};
        default:    k = '{10'd256, 10'd359, 10'd88, 10'd183, 10'd454};
      endcase
    end else begin
      case (mtx)
        MTX_BT709:  k = '{10'd298, 10'd460, 10'd55, 10'd137, 10'd543};
        MTX_BT2020: k = '{10'd298, 10'd410, 10'd47, 10'd122, 10'd584};
        default:    k = '{10'd298, 10'd409, 10'd100, 10'd208, 10'd516};
      endcase
    end
    return k;
  endfunction

endpackage

// ----- hdl/prc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// prc_cfg_regs
// Configuration register bank: matrix select, range and source format.
// ----------------------------------------------------------------------------
module prc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [prc_pkg::CFG_IDX_W-1:0]  index,
  input  logic [prc_pkg::CFG_DATA_W-1:0] data,
  output prc_pkg::cfg_t                  cfg
);
  import prc_pkg::*;

  // unknown indexes fall through and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (we) begin
      if (index == REG_MATRIX_SELECT) begin
        cfg.matrix_select <= data[1:0];
      end else if (index == REG_FULL_RANGE) begin
        cfg.full_range <= data[0];
      end else if (index == REG_SOURCE_FORMAT) begin
        cfg.source_format <= data;
      end
    end
  end

endmodule

// ----- hdl/prc_convert.sv -----
// ----------------------------------------------------------------------------
// prc_convert
// Combinational pixel conversion: YCbCr matrix with round and clamp, or
// byte reordering for the packed RGB and grey formats.
// ----------------------------------------------------------------------------
module prc_convert (
  input  prc_pkg::pixel_t pix,
  input  prc_pkg::cfg_t   cfg,
  output prc_pkg::rgba_t  rgba
);
  import prc_pkg::*;

  coef_t                    k;
  logic signed [OPND_W-1:0] lum;
  logic signed [OPND_W-1:0] cb;
  logic signed [OPND_W-1:0] cr;
  logic signed [SUM_W-1:0]  base;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_g;
  logic signed [SUM_W-1:0]  sum_b;
  logic [BYTE_W-1:0]        yr, yg, yb;

  // (v + 128) >>> 8, then clamp to a byte
  function automatic logic [BYTE_W-1:0] round_clamp(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-9:0] q;
    t = v + SUM_W'(128);
    q = $signed(t[SUM_W-1:8]);
    if (q[SUM_W-9]) begin
      return '0;
    end else if (q > $signed((SUM_W-8)'(255))) begin
      return '1;
    end
    return q[BYTE_W-1:0];
  endfunction

  always_comb begin
    k    = coef_lookup(cfg.matrix_select, cfg.full_range);
    lum  = cfg.full_range ? $signed({2'b00, pix.first})
                          : $signed({2'b00, pix.first}) - OPND_W'(16);
    cb   = $signed({2'b00, pix.second}) - OPND_W'(128);
    cr   = $signed({2'b00, pix.third}) - OPND_W'(128);
    base = SUM_W'($signed({1'b0, k.luma})) * SUM_W'(lum);
    sum_r = base + SUM_W'($signed({1'b0, k.r_cr})) * SUM_W'(cr);
    sum_g = base - SUM_W'($signed({1'b0, k.g_cb})) * SUM_W'(cb)
                 - SUM_W'($signed({1'b0, k.g_cr})) * SUM_W'(cr);
    sum_b = base + SUM_W'($signed({1'b0, k.b_cb})) * SUM_W'(cb);
    yr = round_clamp(sum_r);
    yg = round_clamp(sum_g);
    yb = round_clamp(sum_b);
  end

  always_comb begin
    rgba.alpha = '1;
    case (cfg.source_format)
      FMT_RGB24: begin
        rgba.red   = pix.first;
        rgba.green = pix.second;
        rgba.blue  = pix.third;
      end
      FMT_BGR24: begin
        rgba.red   = pix.third;
        rgba.green = pix.second;
        rgba.blue  = pix.first;
      end
      FMT_BGRA32: begin
        rgba.red   = pix.third;
        rgba.green = pix.second;
        rgba.blue  = pix.first;
        rgba.alpha = pix.fourth;
      end
      FMT_GRAY8: begin
        rgba.red   = pix.first;
        rgba.green = pix.first;
        rgba.blue  = pix.first;
      end
      default: begin
        // YCbCr, and the unused format codes
        rgba.red   = yr;
        rgba.green = yg;
        rgba.blue  = yb;
      end
    endcase
  end

endmodule

// ----- hdl/pixel_to_rgba_converter.sv -----
// ----------------------------------------------------------------------------
// pixel_to_rgba_converter
// Converts one pixel word (YCbCr, RGB24, BGR24, BGRA32 or GRAY8) into one
// RGBA word per clock while the output is not stalled.
// Path: an accepted word goes into the input register, then the result
// register, with the matrix multiply-add-clamp between them.
// Throughput: one word per cycle unless rgba_ready stalls the output.
// Reset: synchronous, clears both valid flags and all configuration registers
// to zero (BT.601, limited range, YCbCr).
// ----------------------------------------------------------------------------
module pixel_to_rgba_converter (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0] cfg_data,
  // pixel input channel
  input  logic                           pixel_valid,
  output logic                           pixel_ready,
  input  logic [prc_pkg::BYTE_W-1:0]     first_component,
  input  logic [prc_pkg::BYTE_W-1:0]     second_component,
  input  logic [prc_pkg::BYTE_W-1:0]     third_component,
  input  logic [prc_pkg::BYTE_W-1:0]     fourth_component,
  // RGBA output channel
  output logic                           rgba_valid,
  input  logic                           rgba_ready,
  output logic [prc_pkg::BYTE_W-1:0]     red,
  output logic [prc_pkg::BYTE_W-1:0]     green,
  output logic [prc_pkg::BYTE_W-1:0]     blue,
  output logic [prc_pkg::BYTE_W-1:0]     alpha
);
  import prc_pkg::*;

  cfg_t   cfg;
  logic   s1_valid;
  pixel_t s1_pix;
  logic   s1_adv;
  rgba_t  conv;
  rgba_t  out_pix;

  // The user must change configuration only while the pipe is empty (not enforced
  // by the block itself), since the converter reads the live registers.
  prc_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Stage 1 moves on whenever the result register is empty or draining.
  // The input side can then refill stage 1 in the same cycle, so a
  // stalled result never blocks a new word while stage 1 is free.
  assign s1_adv      = s1_valid && (!rgba_valid || rgba_ready);
  assign pixel_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  // input register payload, no reset
  always_ff @(posedge clk) begin
    if (pixel_valid && pixel_ready) begin
      s1_pix <= '{first_component, second_component, third_component,
                  fourth_component};
    end
  end

  prc_convert u_convert (
    .pix  (s1_pix),
    .cfg  (cfg),
    .rgba (conv)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rgba_valid <= 1'b0;
    end else if (!rgba_valid || rgba_ready) begin
      rgba_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix <= conv;
    end
  end

  assign red   = out_pix.red;
  assign green = out_pix.green;
  assign blue  = out_pix.blue;
  assign alpha = out_pix.alpha;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // an accepted word lands in stage 1
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> s1_valid)
    else $error("accepted pixel word not held in stage 1");

  // a word leaving stage 1 always appears as a result
  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> rgba_valid)
    else $error("stage 1 word lost on the way to the result register");

  // stage 1 must hold while the result register is full and stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rgba_valid && !rgba_ready && s1_valid |-> !s1_adv && !pixel_ready)
    else $error("stage 1 advanced into a stalled result register");

  // an empty stage 1 is always open for input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> pixel_ready)
    else $error("input not ready while stage 1 empty");

endmodule
